// File: design/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg: shared types and constants for the length-prefix frame decoder
// Phase codes, result codes, the result record and reset/default values.
// ----------------------------------------------------------------------------
package lpfd_pkg;

    localparam int unsigned LEN_W       = 32;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned RES_KIND_W  = 2;
    localparam int unsigned PREFIX_LEN  = 4;
    localparam int unsigned PREFIX_CNT_W = 2;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd65535;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    typedef enum logic [1:0] {
        PH_PREFIX  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ERROR   = 2'd2
    } phase_t;

    typedef logic [RES_KIND_W-1:0] res_kind_t;

    localparam res_kind_t RES_PAYLOAD  = 2'd0;
    localparam res_kind_t RES_EMPTY    = 2'd1;
    localparam res_kind_t RES_OVERSIZE = 2'd2;

    localparam logic [PREFIX_CNT_W-1:0] PREFIX_LAST = PREFIX_CNT_W'(PREFIX_LEN - 1);

    typedef struct packed {
        res_kind_t           kind;
        logic [BYTE_W-1:0]   data;
        logic                last;
    } res_t;

endpackage

// File: design/lpfd_front.sv
// ----------------------------------------------------------------------------
// lpfd_front: input beat parser
// Gathers the big-endian length prefix, tracks payload count and error state,
// and pushes at most one result record per accepted beat into the queue.
// ----------------------------------------------------------------------------
module lpfd_front
    import lpfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [LEN_W-1:0]      cfg_wdata,
    input  logic                  in_valid,
    input  logic                  in_resync,
    input  logic [BYTE_W-1:0]     in_byte,
    output logic                  in_ready,
    input  logic                  q_full,
    output logic                  q_push,
    output res_t                  q_data
);

    phase_t                    phase_reg, phase_next;
    logic [PREFIX_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [LEN_W-1:0]          shift_reg, shift_next;
    logic [LEN_W-1:0]          remain_reg, remain_next;
    logic [LEN_W-1:0]          max_len_reg;
    logic [LEN_W-1:0]          shifted;
    logic [LEN_W-1:0]          remain_dec;
    logic                      accept;

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign shifted    = {shift_reg[LEN_W-BYTE_W-1:0], in_byte};
    assign remain_dec = remain_reg - LEN_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_PREFIX;
            cnt_reg     <= '0;
            shift_reg   <= '0;
            remain_reg  <= '0;
            max_len_reg <= MAX_LEN_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            shift_reg  <= shift_next;
            remain_reg <= remain_next;
            if (cfg_we)
            begin
                max_len_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        shift_next  = shift_reg;
        remain_next = remain_reg;
        q_push      = 1'b0;
        q_data      = '0;

        if (accept)
        begin
            if (in_resync)
            begin
                phase_next  = PH_PREFIX;
                cnt_next    = '0;
                shift_next  = '0;
                remain_next = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_PREFIX:
                    begin
                        if (cnt_reg != PREFIX_LAST)
                        begin
                            shift_next = shifted;
                            cnt_next   = cnt_reg + PREFIX_CNT_W'(1);
                        end
                        else
                        begin
                            cnt_next   = '0;
                            shift_next = '0;
                            if (shifted > max_len_reg)
                            begin
                                phase_next  = PH_ERROR;
                                remain_next = '0;
                                q_push      = 1'b1;
                                q_data.kind = RES_OVERSIZE;
                                q_data.last = 1'b1;
                            end
                            else if (shifted == '0)
                            begin
                                q_push      = 1'b1;
                                q_data.kind = RES_EMPTY;
                                q_data.last = 1'b1;
                            end
                            else
                            begin
                                remain_next = shifted;
                                phase_next  = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        remain_next = remain_dec;
                        q_push      = 1'b1;
                        q_data.kind = RES_PAYLOAD;
                        q_data.data = in_byte;
                        q_data.last = (remain_dec == '0);
                        if (remain_dec == '0)
                        begin
                            phase_next = PH_PREFIX;
                        end
                    end
                    default:
                    begin
                        // discarding until resync
                    end
                endcase
            end
        end
    end

endmodule

// File: design/lpfd_queue.sv
// ----------------------------------------------------------------------------
// lpfd_queue: result queue
// Small circular buffer between the parser and the output stage.
// ----------------------------------------------------------------------------
module lpfd_queue
    import lpfd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  res_t  push_data,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output res_t  pop_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    res_t              mem [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic              do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// File: design/lpfd_back.sv
// ----------------------------------------------------------------------------
// lpfd_back: output stage
// Registered master-side beat, refilled from the queue whenever it drains.
// ----------------------------------------------------------------------------
module lpfd_back
    import lpfd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_not_empty,
    input  res_t  q_data,
    output logic  q_pop,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_data
);

    logic  valid_reg;
    res_t  data_reg;

    assign q_pop     = q_not_empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            data_reg <= q_data;
        end
    end

endmodule

// File: design/length_prefix_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// length_prefix_frame_decoder_core: 32-bit big-endian length-prefix deframer
//
//   channel  dir  handshake           payload                  beat contents
//   s_*      in   s_tvalid s_tready   s_tdata s_tuser          stream byte or resync
//   m_*      out  m_tvalid m_tready   m_tdata m_tuser m_tlast  payload byte / empty / error
//   cfg_*    in   cfg_we              cfg_wdata                max payload length
//
// One input beat per cycle while the result queue has room; a result is written
// into the queue at the accepting edge and then loaded into the output register for m_*.
// Throughput is set by the parser's state update (shift, 32-bit
// compare, 32-bit decrement). s_tready drops only while the result queue is full.
// Reset clears the parser to prefix collection and sets the maximum to 65535.
// ----------------------------------------------------------------------------
module length_prefix_frame_decoder_core
    import lpfd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LEN_W-1:0]   cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] stream_byte
    input  logic [0:0]         s_tuser,   // [0] kind
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // [7:0] payload_byte
    output logic [1:0]         m_tuser,   // [1:0] result_kind
    output logic               m_tlast    // frame_last
);

    logic  q_full, q_push, q_not_empty, q_pop;
    res_t  q_in, q_out, out_rec;

    lpfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_resync (s_tuser[0]),
        .in_byte   (s_tdata),
        .in_ready  (s_tready),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    lpfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    lpfd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (out_rec)
    );

    assign m_tdata = out_rec.data;
    assign m_tuser = out_rec.kind;
    assign m_tlast = out_rec.last;

`ifndef SYNTHESIS
    // resync beats never produce a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0]) |-> !q_push)
        else $error("resync beat produced a result");

    // empty and error results are frame ends with zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != RES_PAYLOAD) |-> (m_tlast && m_tdata == '0))
        else $error("non-payload result malformed");

    // never push while the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> s_tready)
        else $error("push into full queue");
`endif

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for length_prefix_frame_decoder_core
// Drives prefixed frames, resyncs and noise bytes through the byte stream,
// predicts each result beat with a cycle-free model of the deframer and
// compares every output beat field by field. Ready and valid idle at
// random, with one long receiver hold-off so the result queue backs up.
// ----------------------------------------------------------------------------
module tb_top;
    import lpfd_pkg::*;

    localparam logic        KIND_BYTE      = 1'b0;
    localparam logic        KIND_RESYNC    = 1'b1;
    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned SQUEEZE_CYCLES = 160;
    localparam int unsigned IDLE_PCT       = 22;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } beat_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [LEN_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = '0;
    logic [0:0]       s_tuser   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [7:0]       m_tdata;
    logic [1:0]       m_tuser;
    logic             m_tlast;

    beat_t       pending_beats[$];
    res_t        expected_results[$];
    int unsigned errors       = 0;
    int unsigned cycles       = 0;
    int unsigned beats_queued = 0;
    int unsigned hold_left    = 0;
    bit          calm         = 1'b0;
    bit          squeeze_go   = 1'b0;
    bit          squeeze_done = 1'b0;

    // deframer state as seen by the predictor
    phase_t                  ph;
    logic [PREFIX_CNT_W-1:0] prefix_seen;
    logic [LEN_W-1:0]        len_acc;
    logic [LEN_W-1:0]        remaining;
    logic [LEN_W-1:0]        max_len;

    length_prefix_frame_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void expect_result(res_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void deframe_predict(logic kind, logic [7:0] b);
        if (kind == KIND_RESYNC)
        begin
            ph          = PH_PREFIX;
            prefix_seen = '0;
            len_acc     = '0;
            remaining   = '0;
            return;
        end
        case (ph)
            PH_PREFIX:
            begin
                len_acc = {len_acc[LEN_W-9:0], b};
                if (prefix_seen != PREFIX_LAST)
                    prefix_seen = prefix_seen + PREFIX_CNT_W'(1);
                else
                begin
                    prefix_seen = '0;
                    if (len_acc > max_len)
                    begin
                        ph        = PH_ERROR;
                        len_acc   = '0;
                        remaining = '0;
                        expect_result(res_t'{RES_OVERSIZE, 8'h00, 1'b1});
                    end
                    else if (len_acc == '0)
                        expect_result(res_t'{RES_EMPTY, 8'h00, 1'b1});
                    else
                    begin
                        remaining = len_acc;
                        len_acc   = '0;
                        ph        = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                remaining = remaining - LEN_W'(1);
                expect_result(res_t'{RES_PAYLOAD, b, remaining == '0});
                if (remaining == '0)
                    ph = PH_PREFIX;
            end
            default:
            begin
                // error phase: byte dropped
            end
        endcase
    endfunction

    task automatic put_beat(logic kind, logic [7:0] b);
        pending_beats.insert(pending_beats.size(), beat_t'{kind, b});
        beats_queued++;
    endtask

    task automatic put_prefix(logic [LEN_W-1:0] len);
        for (int i = 3; i >= 0; i--)
            put_beat(KIND_BYTE, len[8*i +: 8]);
    endtask

    task automatic put_payload(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            put_beat(KIND_BYTE, 8'($urandom_range(255)));
    endtask

    task automatic random_traffic(int unsigned n, int unsigned cur_max);
        int unsigned start;
        int unsigned pick;
        int unsigned len;
        start = beats_queued;
        while (beats_queued - start < n)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                len = $urandom_range(cur_max + 2);
                put_prefix(len);
                if (len <= cur_max)
                    put_payload(len);
                else
                begin
                    put_payload($urandom_range(3));
                    put_beat(KIND_RESYNC, 8'($urandom_range(255)));
                end
            end
            else if (pick < 80)
                put_beat(KIND_RESYNC, 8'($urandom_range(255)));
            else if (pick < 88)
            begin
                // frame cut short by a resync
                len = $urandom_range(cur_max, 2);
                put_prefix(len);
                put_payload($urandom_range(len - 1));
                put_beat(KIND_RESYNC, 8'($urandom_range(255)));
            end
            else if (pick < 94)
            begin
                put_prefix($urandom);
                put_payload($urandom_range(3));
                put_beat(KIND_RESYNC, 8'($urandom_range(255)));
            end
            else
            begin
                // stray byte knocks the framing out of step
                put_payload(1);
                if ($urandom_range(1) == 1)
                    put_beat(KIND_RESYNC, 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic settle();
        while (pending_beats.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_max(logic [LEN_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_beats.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_beats[0].kind;
                s_tdata  <= pending_beats[0].data;
                void'(pending_beats.pop_front());
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
    end

    // one long hold-off on the result side
    always @(posedge clk)
    begin
        if (squeeze_go && !squeeze_done)
        begin
            hold_left    <= SQUEEZE_CYCLES;
            squeeze_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // predict on input beats, check output beats
    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        res_t want;
        if (!rst_n)
        begin
            ph          = PH_PREFIX;
            prefix_seen = '0;
            len_acc     = '0;
            remaining   = '0;
            max_len     = MAX_LEN_RESET;
        end
        else
        begin
            if (cfg_we)
                max_len = cfg_wdata;
            if (s_tvalid && s_tready)
                deframe_predict(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result beat: result_kind %0d payload_byte %0h %s %0b",
                           m_tuser, m_tdata, "frame_last", m_tlast);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.kind)
                    begin
                        $error("result_kind: expected %0d, actual %0d", want.kind, m_tuser);
                        errors++;
                    end
                    if (m_tdata !== want.data)
                    begin
                        $error("payload_byte: expected %0h, actual %0h", want.data, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("frame_last: expected %0b, actual %0b", want.last, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default maximum: one-byte frame, empty frame, length at and above max
        put_prefix(32'd1);
        put_beat(KIND_BYTE, 8'hFF);
        put_prefix(32'd0);
        put_prefix(32'd65535);
        put_beat(KIND_BYTE, 8'h00);
        put_beat(KIND_BYTE, 8'hA5);
        put_beat(KIND_RESYNC, 8'h00);
        put_prefix(32'd65536);
        put_beat(KIND_BYTE, 8'hFF);
        put_beat(KIND_BYTE, 8'h00);
        put_beat(KIND_RESYNC, 8'h00);
        put_beat(KIND_BYTE, 8'h12);
        put_beat(KIND_BYTE, 8'h34);
        put_beat(KIND_RESYNC, 8'hFF);
        settle();

        // max of zero: only empty frames pass
        write_max('0);
        put_prefix(32'd0);
        put_prefix(32'd1);
        put_beat(KIND_BYTE, 8'h5A);
        put_beat(KIND_RESYNC, 8'h00);
        put_prefix(32'd0);
        settle();

        // all-ones max: an all-ones length is accepted
        write_max('1);
        put_prefix('1);
        put_payload(3);
        put_beat(KIND_RESYNC, 8'h00);
        put_prefix(32'd2);
        put_payload(2);
        settle();

        write_max(32'd24);
        random_traffic(240, 24);
        squeeze_go = 1'b1;
        settle();

        write_max(32'd7);
        calm = 1'b1;
        random_traffic(210, 7);
        settle();

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
